/* rtl/core/bfd_pkg.sv */
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants, weight table, weight function and cell payload type of
// the binary fraction to decimal converter.
// ----------------------------------------------------------------------------
package bfd_pkg;

    // Field widths.
    localparam int unsigned FRAC_W  = 32;
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned POS_W   = 5;

    // Fraction bits handled by one cell, and the deepest chain that can occur.
    localparam int unsigned DEFAULT_CELL_BITS = 2;
    localparam int unsigned MAX_DEPTH         = FRAC_W + 1;

    // Final rounding of the unsigned sum.
    localparam logic [SUM_W-1:0] ROUND_BIAS = 32'h0000_0008;
    localparam logic [SUM_W-1:0] ROUND_MASK = 32'hFFFF_FFF0;

    // Weight of the sign bit in Q1.31 form: minus one billion, modulo 2^32.
    localparam logic [SUM_W-1:0] SIGN_WEIGHT = 32'hC465_3600;

    // Rounded decimal weight of each bit of an unsigned fraction, times 1e9.
    localparam logic [SUM_W-1:0] UNSIGNED_WEIGHTS [FRAC_W] = '{
        32'd0,         32'd0,         32'd1,         32'd2,
        32'd4,         32'd7,         32'd15,        32'd30,
        32'd60,        32'd119,       32'd238,       32'd477,
        32'd954,       32'd1907,      32'd3815,      32'd7629,
        32'd15259,     32'd30518,     32'd61035,     32'd122070,
        32'd244141,    32'd488281,    32'd976563,    32'd1953125,
        32'd3906250,   32'd7812500,   32'd15625000,  32'd31250000,
        32'd62500000,  32'd125000000, 32'd250000000, 32'd500000000
    };

    // Weight of one fraction bit for the selected mode.
    function automatic logic [SUM_W-1:0] bit_weight(input logic [POS_W-1:0] pos,
                                                    input logic mode);
        logic [SUM_W-1:0] w;
        if (!mode)
        begin
            w = UNSIGNED_WEIGHTS[pos];
        end
        else if (pos == POS_W'(FRAC_W - 1))
        begin
            w = SIGN_WEIGHT;
        end
        else
        begin
            w = UNSIGNED_WEIGHTS[pos + POS_W'(1)];
        end
        return w;
    endfunction

    // Payload handed from one cell to the next.
    typedef struct packed {
        logic [FRAC_W-1:0] fraction_bits;
        logic              mode;
        logic [SUM_W-1:0]  sum;
    } cell_data_t;

endpackage

/* rtl/core/bfd_sample_if.sv */
// ----------------------------------------------------------------------------
// bfd_sample_if
// Input channel of the converter: one binary fraction and its mode.
// ----------------------------------------------------------------------------
interface bfd_sample_if;

    logic                          valid;
    logic                          ready;
    logic [bfd_pkg::FRAC_W-1:0]    fraction_bits;
    logic                          mode;

    modport source (output valid, output fraction_bits, output mode, input ready);
    modport sink   (input valid, input fraction_bits, input mode, output ready);

endinterface

/* rtl/core/bfd_result_if.sv */
// ----------------------------------------------------------------------------
// bfd_result_if
// Output channel of the converter: the decimal value scaled by one billion.
// ----------------------------------------------------------------------------
interface bfd_result_if;

    logic                              valid;
    logic                              ready;
    logic signed [bfd_pkg::VALUE_W-1:0] decimal_value;

    modport source (output valid, output decimal_value, input ready);
    modport sink   (input valid, input decimal_value, output ready);

endinterface

/* rtl/core/bfd_cell.sv */
// ----------------------------------------------------------------------------
// bfd_cell
// One cell of the conversion chain: adds the weights of its own group of
// fraction bits to the running sum and hands the item to the next cell.
// ----------------------------------------------------------------------------
module bfd_cell #(
    parameter int unsigned CELL_BITS  = bfd_pkg::DEFAULT_CELL_BITS,
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  bfd_pkg::cell_data_t up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output bfd_pkg::cell_data_t dn_data
);

    logic                valid_reg;
    logic                valid_next;
    bfd_pkg::cell_data_t data_reg;
    bfd_pkg::cell_data_t data_next;
    logic                load;

    // The cell takes a new item when it is empty or its item moves on.
    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Add the weights of the bits that this cell owns.
    always_comb
    begin
        data_next = up_data;
        for (int unsigned j = 0; j < CELL_BITS; j++)
        begin
            if (up_data.fraction_bits[CELL_INDEX * CELL_BITS + j])
            begin
                data_next.sum = data_next.sum
                    + bfd_pkg::bit_weight(bfd_pkg::POS_W'(CELL_INDEX * CELL_BITS + j),
                                          up_data.mode);
            end
        end
    end

    // Occupancy of the cell.
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (dn_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/binary_fraction_to_decimal.sv */
// ----------------------------------------------------------------------------
// binary_fraction_to_decimal
// Converts a 32-bit binary fraction, unsigned or Q1.31, into its value times
// one billion by summing rounded per-bit decimal weights along a cell chain.
// ----------------------------------------------------------------------------
// Path from sample transfer to result: one register in each of the 32 / CELL_BITS
// cells, then the output register, which does the rounding.
// Throughput: one item per cycle; every cell and the output register move on
// together as long as the result side takes transfers.
// Reset clears the valid flag of every cell and of the output register.
// ----------------------------------------------------------------------------
module binary_fraction_to_decimal #(
    parameter int unsigned CELL_BITS = bfd_pkg::DEFAULT_CELL_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    bfd_sample_if.sink   sample,
    bfd_result_if.source result
);

    localparam int unsigned NUM_CELLS = bfd_pkg::FRAC_W / CELL_BITS;

    logic                valid_chain [NUM_CELLS+1];
    logic                ready_chain [NUM_CELLS+1];
    bfd_pkg::cell_data_t data_chain  [NUM_CELLS+1];

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [bfd_pkg::VALUE_W-1:0]  value_reg;
    logic signed [bfd_pkg::VALUE_W-1:0]  value_next;
    logic [bfd_pkg::SUM_W-1:0]           rounded;
    logic                                out_load;

    // Head of the chain: the sample enters with an empty sum.
    assign valid_chain[0]             = sample.valid;
    assign sample.ready               = ready_chain[0];
    assign data_chain[0].fraction_bits = sample.fraction_bits;
    assign data_chain[0].mode          = sample.mode;
    assign data_chain[0].sum           = '0;

    // Row of cells, each owning CELL_BITS fraction bits.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        bfd_cell #(
            .CELL_BITS  (CELL_BITS),
            .CELL_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_chain[i]),
            .up_ready (ready_chain[i]),
            .up_data  (data_chain[i]),
            .dn_valid (valid_chain[i+1]),
            .dn_ready (ready_chain[i+1]),
            .dn_data  (data_chain[i+1])
        );
    end

    // Output register: round in unsigned mode, then keep the low 31 bits.
    assign ready_chain[NUM_CELLS] = !out_valid_reg || result.ready;
    assign out_load               = valid_chain[NUM_CELLS] && ready_chain[NUM_CELLS];

    always_comb
    begin
        rounded = (data_chain[NUM_CELLS].sum + bfd_pkg::ROUND_BIAS) & bfd_pkg::ROUND_MASK;
        if (data_chain[NUM_CELLS].mode)
        begin
            value_next = data_chain[NUM_CELLS].sum[bfd_pkg::VALUE_W-1:0];
        end
        else
        begin
            value_next = rounded[bfd_pkg::VALUE_W-1:0];
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg <= value_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.decimal_value = value_reg;

endmodule

/* rtl/core/bfd_checker.sv */
// ----------------------------------------------------------------------------
// bfd_checker
// Port-level checks of the converter: result range, stall behaviour and the
// count of items in flight.
// ----------------------------------------------------------------------------
module bfd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              r_valid,
    input logic                              r_ready,
    input logic signed [bfd_pkg::VALUE_W-1:0] r_value
);

    localparam int unsigned CNT_W = $clog2(bfd_pkg::MAX_DEPTH + 2);

    localparam logic signed [bfd_pkg::VALUE_W-1:0] VALUE_MAX = 31'sd1000000000;
    localparam logic signed [bfd_pkg::VALUE_W-1:0] VALUE_MIN = -31'sd1000000000;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             s_xfer;
    logic             r_xfer;

    assign s_xfer = s_valid && s_ready;
    assign r_xfer = r_valid && r_ready;

    // Items taken in but not yet delivered.
    always_comb
    begin
        count_next = count_reg;
        if (s_xfer && !r_xfer)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (r_xfer && !s_xfer)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A stalled result stays in place.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_value))
        else $error("result changed while stalled");

    // The value stays within plus and minus one billion.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (r_value <= VALUE_MAX) && (r_value >= VALUE_MIN))
        else $error("result out of range");

    // No result appears without an item in flight.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> count_reg != '0)
        else $error("result without a matching sample");

    // Items in flight never exceed the register count of the deepest possible chain.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(bfd_pkg::MAX_DEPTH))
        else $error("more items in flight than the chain can hold");

endmodule

bind binary_fraction_to_decimal bfd_checker u_bfd_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample.valid),
    .s_ready (sample.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_value (result.decimal_value)
);
